// File: hdl/bmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants, types and address map of the banked memory map.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int ROM_BANKS      = 128;
    localparam int VRAM_BANKS     = 2;
    localparam int CART_RAM_BANKS = 4;
    localparam int WRAM_BANKS     = 7;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_TDATA_W = 24;

    localparam int ROM_BANK_W  = 7;
    localparam int VRAM_BANK_W = 1;
    localparam int CRAM_BANK_W = 2;
    localparam int WRAM_BANK_W = 3;

    localparam int ROM_PAGE_W  = 14;
    localparam int VRAM_PAGE_W = 13;
    localparam int CRAM_PAGE_W = 13;
    localparam int WRAM_PAGE_W = 12;
    localparam int HIGH_W      = 9;

    // page 0 of ROM and work RAM is the fixed page, banks follow from page 1
    localparam int ROM_DEPTH  = (ROM_BANKS + 1) * (1 << ROM_PAGE_W);
    localparam int VRAM_DEPTH = VRAM_BANKS * (1 << VRAM_PAGE_W);
    localparam int CRAM_DEPTH = CART_RAM_BANKS * (1 << CRAM_PAGE_W);
    localparam int WRAM_DEPTH = (WRAM_BANKS + 1) * (1 << WRAM_PAGE_W);
    localparam int HIGH_DEPTH = 1 << HIGH_W;

    localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);
    localparam int ROM_PG_W   = ROM_IDX_W - ROM_PAGE_W;
    localparam int VRAM_IDX_W = $clog2(VRAM_DEPTH);
    localparam int CRAM_IDX_W = $clog2(CRAM_DEPTH);
    localparam int WRAM_IDX_W = $clog2(WRAM_DEPTH);

    localparam int MAX_A = (ROM_DEPTH > VRAM_DEPTH) ? ROM_DEPTH : VRAM_DEPTH;
    localparam int MAX_B = (CRAM_DEPTH > WRAM_DEPTH) ? CRAM_DEPTH : WRAM_DEPTH;
    localparam int MAX_C = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int CLR_DEPTH = (MAX_C > HIGH_DEPTH) ? MAX_C : HIGH_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int CMD_IDX_W = $clog2(CLR_DEPTH);

    localparam logic [ADDR_W-1:0] ADDR_ROMX = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_CRAM = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_WRAM = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_WRMX = 16'hD000;
    localparam logic [ADDR_W-1:0] ADDR_ECHO = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_ECHX = 16'hF000;
    localparam logic [ADDR_W-1:0] ADDR_OAM  = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_HOLE = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ADDR_IO   = 16'hFF00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROM_BANK  = 2'd0,
        REG_VRAM_BANK = 2'd1,
        REG_CRAM_BANK = 2'd2,
        REG_WRAM_BANK = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        TGT_ROM  = 3'd0,
        TGT_VRAM = 3'd1,
        TGT_CRAM = 3'd2,
        TGT_WRAM = 3'd3,
        TGT_HIGH = 3'd4,
        TGT_NONE = 3'd5
    } t_target;

    typedef struct packed {
        logic                  write;
        t_target               target;
        logic [CMD_IDX_W-1:0]  index;
        logic [DATA_W-1:0]     data;
    } t_cmd;

endpackage

// File: hdl/bmm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_front
// Bank registers, address decode and transaction intake.
// ----------------------------------------------------------------------------
module bmm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bmm_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_q_ready,
    input  logic                           i_clr_done,
    output logic                           o_push,
    output bmm_pkg::t_cmd                  o_cmd
);
    import bmm_pkg::*;

    logic [ROM_BANK_W-1:0]  r_rom_bank;
    logic [VRAM_BANK_W-1:0] r_vram_bank;
    logic [CRAM_BANK_W-1:0] r_cram_bank;
    logic [WRAM_BANK_W-1:0] r_wram_bank;

    logic [ADDR_W-1:0]      addr;
    logic [ROM_PG_W-1:0]    rom_pg;
    logic [WRAM_BANK_W-1:0] wram_pg;

    // bank values are masked to width, then clamped to the last bank present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank  <= '0;
            r_vram_bank <= '0;
            r_cram_bank <= '0;
            r_wram_bank <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROM_BANK: begin
                    if (32'(i_cfg_data[ROM_BANK_W-1:0]) >= ROM_BANKS)
                        r_rom_bank <= ROM_BANK_W'(ROM_BANKS - 1);
                    else
                        r_rom_bank <= i_cfg_data[ROM_BANK_W-1:0];
                end
                REG_VRAM_BANK: begin
                    if (32'(i_cfg_data[VRAM_BANK_W-1:0]) >= VRAM_BANKS)
                        r_vram_bank <= VRAM_BANK_W'(VRAM_BANKS - 1);
                    else
                        r_vram_bank <= i_cfg_data[VRAM_BANK_W-1:0];
                end
                REG_CRAM_BANK: begin
                    if (32'(i_cfg_data[CRAM_BANK_W-1:0]) >= CART_RAM_BANKS)
                        r_cram_bank <= CRAM_BANK_W'(CART_RAM_BANKS - 1);
                    else
                        r_cram_bank <= i_cfg_data[CRAM_BANK_W-1:0];
                end
                REG_WRAM_BANK: begin
                    if (32'(i_cfg_data[WRAM_BANK_W-1:0]) >= WRAM_BANKS)
                        r_wram_bank <= WRAM_BANK_W'(WRAM_BANKS - 1);
                    else
                        r_wram_bank <= i_cfg_data[WRAM_BANK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign addr    = i_s_tdata[ADDR_W-1:0];
    assign rom_pg  = ROM_PG_W'(r_rom_bank) + ROM_PG_W'(1);
    assign wram_pg = r_wram_bank + WRAM_BANK_W'(1);

    always_comb begin
        o_cmd.write = i_s_tuser[0];
        o_cmd.data  = i_s_tdata[ADDR_W +: DATA_W];
        if (addr < ADDR_ROMX) begin
            o_cmd.target = TGT_ROM;
            o_cmd.index  = CMD_IDX_W'(addr[ROM_PAGE_W-1:0]);
        end else if (addr < ADDR_VRAM) begin
            o_cmd.target = TGT_ROM;
            o_cmd.index  = CMD_IDX_W'({rom_pg, addr[ROM_PAGE_W-1:0]});
        end else if (addr < ADDR_CRAM) begin
            o_cmd.target = TGT_VRAM;
            o_cmd.index  = CMD_IDX_W'(VRAM_IDX_W'({r_vram_bank, addr[VRAM_PAGE_W-1:0]}));
        end else if (addr < ADDR_WRAM) begin
            o_cmd.target = TGT_CRAM;
            o_cmd.index  = CMD_IDX_W'(CRAM_IDX_W'({r_cram_bank, addr[CRAM_PAGE_W-1:0]}));
        end else if (addr < ADDR_WRMX || (addr >= ADDR_ECHO && addr < ADDR_ECHX)) begin
            o_cmd.target = TGT_WRAM;
            o_cmd.index  = CMD_IDX_W'(addr[WRAM_PAGE_W-1:0]);
        end else if (addr < ADDR_OAM) begin
            o_cmd.target = TGT_WRAM;
            o_cmd.index  = CMD_IDX_W'(WRAM_IDX_W'({wram_pg, addr[WRAM_PAGE_W-1:0]}));
        end else if (addr >= ADDR_HOLE && addr < ADDR_IO) begin
            o_cmd.target = TGT_NONE;
            o_cmd.index  = '0;
        end else begin
            // sprite table, I/O, high RAM and IE share one 512-byte page
            o_cmd.target = TGT_HIGH;
            o_cmd.index  = CMD_IDX_W'(addr[HIGH_W-1:0]);
        end
    end

    assign o_s_tready = i_q_ready && i_clr_done;
    assign o_push     = i_s_tvalid && o_s_tready;

endmodule

// File: hdl/bmm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_queue
// Two-entry command queue between decode and memory access.
// ----------------------------------------------------------------------------
module bmm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bmm_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output bmm_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import bmm_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_slot[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push)
                r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)
                r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

endmodule

// File: hdl/bmm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_back
// Memory stores, clearing sweep, read stage and output register.
// ----------------------------------------------------------------------------
module bmm_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  bmm_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_clr_done,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [bmm_pkg::DATA_W-1:0] o_m_tdata,
    output logic [0:0]                 o_m_tuser
);
    import bmm_pkg::*;

    logic [DATA_W-1:0] r_rom  [ROM_DEPTH];
    logic [DATA_W-1:0] r_vram [VRAM_DEPTH];
    logic [DATA_W-1:0] r_cram [CRAM_DEPTH];
    logic [DATA_W-1:0] r_wram [WRAM_DEPTH];
    logic [DATA_W-1:0] r_high [HIGH_DEPTH];

    logic [DATA_W-1:0] r_rom_rd;
    logic [DATA_W-1:0] r_vram_rd;
    logic [DATA_W-1:0] r_cram_rd;
    logic [DATA_W-1:0] r_wram_rd;
    logic [DATA_W-1:0] r_high_rd;

    logic [CLR_W-1:0]  r_clr_cnt;
    logic              r_clr_done;
    logic              clr_on;

    logic              r_s1_valid;
    logic              r_s1_write;
    t_target           r_s1_target;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_bad;

    logic              s1_take;
    logic              wr;
    logic [DATA_W-1:0] s1_data;

    assign clr_on  = !r_clr_done;
    assign s1_take = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_pop   = i_valid && r_clr_done && (!r_s1_valid || s1_take);
    assign wr      = o_pop && i_cmd.write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_done <= 1'b0;
        end else if (clr_on) begin
            if (r_clr_cnt == CLR_W'(CLR_DEPTH - 1))
                r_clr_done <= 1'b1;
            else
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_on && 32'(r_clr_cnt) < ROM_DEPTH)
            r_rom[ROM_IDX_W'(r_clr_cnt)] <= '0;
        else if (wr && i_cmd.target == TGT_ROM)
            r_rom[ROM_IDX_W'(i_cmd.index)] <= i_cmd.data;
        if (o_pop)
            r_rom_rd <= r_rom[ROM_IDX_W'(i_cmd.index)];
    end

    always_ff @(posedge i_clk) begin
        if (clr_on && 32'(r_clr_cnt) < VRAM_DEPTH)
            r_vram[VRAM_IDX_W'(r_clr_cnt)] <= '0;
        else if (wr && i_cmd.target == TGT_VRAM)
            r_vram[VRAM_IDX_W'(i_cmd.index)] <= i_cmd.data;
        if (o_pop)
            r_vram_rd <= r_vram[VRAM_IDX_W'(i_cmd.index)];
    end

    always_ff @(posedge i_clk) begin
        if (clr_on && 32'(r_clr_cnt) < CRAM_DEPTH)
            r_cram[CRAM_IDX_W'(r_clr_cnt)] <= '0;
        else if (wr && i_cmd.target == TGT_CRAM)
            r_cram[CRAM_IDX_W'(i_cmd.index)] <= i_cmd.data;
        if (o_pop)
            r_cram_rd <= r_cram[CRAM_IDX_W'(i_cmd.index)];
    end

    always_ff @(posedge i_clk) begin
        if (clr_on && 32'(r_clr_cnt) < WRAM_DEPTH)
            r_wram[WRAM_IDX_W'(r_clr_cnt)] <= '0;
        else if (wr && i_cmd.target == TGT_WRAM)
            r_wram[WRAM_IDX_W'(i_cmd.index)] <= i_cmd.data;
        if (o_pop)
            r_wram_rd <= r_wram[WRAM_IDX_W'(i_cmd.index)];
    end

    always_ff @(posedge i_clk) begin
        if (clr_on && 32'(r_clr_cnt) < HIGH_DEPTH)
            r_high[HIGH_W'(r_clr_cnt)] <= '0;
        else if (wr && i_cmd.target == TGT_HIGH)
            r_high[HIGH_W'(i_cmd.index)] <= i_cmd.data;
        if (o_pop)
            r_high_rd <= r_high[HIGH_W'(i_cmd.index)];
    end

    always_comb begin
        case (r_s1_target)
            TGT_ROM:  s1_data = r_rom_rd;
            TGT_VRAM: s1_data = r_vram_rd;
            TGT_CRAM: s1_data = r_cram_rd;
            TGT_WRAM: s1_data = r_wram_rd;
            TGT_HIGH: s1_data = r_high_rd;
            default:  s1_data = '0;
        endcase
        if (r_s1_write)
            s1_data = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop)
                r_s1_valid <= 1'b1;
            else if (s1_take)
                r_s1_valid <= 1'b0;
            if (s1_take)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_write  <= i_cmd.write;
            r_s1_target <= i_cmd.target;
        end
        if (s1_take) begin
            r_out_data <= s1_data;
            r_out_bad  <= (r_s1_target == TGT_NONE);
        end
    end

    assign o_clr_done = r_clr_done;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_bad;

endmodule

// File: hdl/banked_memory_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_map
// Banked 16-bit address byte bus with ROM, video, cartridge and work RAM.
// ----------------------------------------------------------------------------
// One read or write transaction is taken per clock when the output side keeps
// up; a result passes through the queue entry, the registered memory read and
// the output register before it is presented. Each transaction reads every
// store at its index, and a write also writes the store that it targets, if any.
// After reset every store is swept to zero one entry per clock over the largest
// store, CLR_DEPTH entries (2,113,536 with the default bank counts); o_s_tready
// stays low until the sweep ends, while bank register writes are taken at any
// time.
module banked_memory_map (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bmm_pkg::IN_TDATA_W-1:0] i_s_tdata,  // address[15:0], write_data[23:16]
    input  logic [0:0]                     i_s_tuser,  // mode (1 = write)
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bmm_pkg::DATA_W-1:0]     o_m_tdata,  // read_data[7:0]
    output logic [0:0]                     o_m_tuser   // bad_region
);
    import bmm_pkg::*;

    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    logic clr_done;
    t_cmd f_cmd;
    t_cmd q_cmd;

    bmm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_ready  (q_ready),
        .i_clr_done (clr_done),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    bmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    bmm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_clr_done (clr_done),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    a_no_intake_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !clr_done |-> !o_s_tready && !o_m_tvalid
    ) else $error("transaction taken or issued during clearing sweep");

    a_hole_reads_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0
    ) else $error("unusable region returned non-zero data");

    a_pop_needs_entry: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) pop |-> q_valid && clr_done
    ) else $error("queue popped while empty or clearing");

    a_push_fits: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) push |-> q_ready
    ) else $error("queue pushed while full");

endmodule

// File: sim/banked_memory_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_map_tb
// Self-checking bench for the banked memory map.
// Read and write transactions are driven across the whole address map while
// the bank registers change between phases. These include the echo regions,
// the unusable hole and out-of-range bank values. A shadow copy of every store
// predicts untyped results, and each result is compared field by field.
// ----------------------------------------------------------------------------
module banked_memory_map_tb;
    import bmm_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 9;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 115;
    localparam int DIR_N       = 25;
    localparam int DRAIN_CYC   = 10;
    localparam int POOL_MAX    = 64;
    // several reset sweeps plus a wide margin for the transactions themselves
    localparam int CYCLE_LIMIT = 3 * CLR_DEPTH + 200_000;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_HRAM = 16'hFF80;
    localparam logic [ADDR_W-1:0] ADDR_IE   = 16'hFFFF;

    typedef enum int {
        AREA_ROM0,
        AREA_ROMX,
        AREA_VRAM,
        AREA_CRAM,
        AREA_WRAM0,
        AREA_WRAMX,
        AREA_OAM,
        AREA_IO,
        AREA_HRAM,
        AREA_IE
    } t_area;

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic              bad;
    } t_result;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic              typed;
        t_result           res;
    } t_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_TDATA_W-1:0] i_s_tdata  = '0;
    logic [0:0]            i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [DATA_W-1:0]     o_m_tdata;
    logic [0:0]            o_m_tuser;

    // directed part: rows with typed results are read straight off the map
    t_row dir_rows [DIR_N] = '{
        '{MODE_READ,  16'h0000, 8'h00, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'h0000, 8'hFF, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'h0000, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'h3FFF, 8'h01, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'h3FFF, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'h4000, 8'hA5, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'hFF80, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_READ,  16'h4000, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'h9FFF, 8'h5A, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'h9FFF, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hA000, 8'hC3, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'hBFFF, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hC000, 8'h11, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'hE000, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hFDFF, 8'h22, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'hDDFF, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hFE9F, 8'h33, 1'b1, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hFEA0, 8'h77, 1'b1, '{8'h00, 1'b1}},
        '{MODE_READ,  16'hFEFF, 8'h00, 1'b1, '{8'h00, 1'b1}},
        '{MODE_READ,  16'hFE9F, 8'h00, 1'b0, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hFF7F, 8'h44, 1'b1, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hFF80, 8'h55, 1'b1, '{8'h00, 1'b0}},
        '{MODE_WRITE, 16'hFFFF, 8'h80, 1'b1, '{8'h00, 1'b0}},
        '{MODE_READ,  16'hFFFF, 8'h00, 1'b0, '{8'h00, 1'b0}}
    };

    int unsigned       sel_rom, sel_vram, sel_cram, sel_wram;
    bit [DATA_W-1:0]   shadow_mem [int unsigned];
    t_result           pending_results [$];
    logic [ADDR_W-1:0] written_addrs [$];

    int errors    = 0;
    int cycles    = 0;
    int n_reads   = 0;
    int n_writes  = 0;
    int n_hole    = 0;
    int stall_left = 0;
    bit idle_en   = 1'b1;

    banked_memory_map u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // address[15:0], write_data[23:16]
        .i_s_tuser  (i_s_tuser),   // mode (1 = write)
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // read_data[7:0]
        .o_m_tuser  (o_m_tuser)    // bad_region
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int unsigned clamp_bank(int unsigned v, int unsigned banks);
        return (v >= banks) ? banks - 1 : v;
    endfunction

    function automatic void apply_bank(t_reg_idx idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_ROM_BANK:  sel_rom  = clamp_bank(32'(val[ROM_BANK_W-1:0]), ROM_BANKS);
            REG_VRAM_BANK: sel_vram = clamp_bank(32'(val[VRAM_BANK_W-1:0]), VRAM_BANKS);
            REG_CRAM_BANK: sel_cram = clamp_bank(32'(val[CRAM_BANK_W-1:0]), CART_RAM_BANKS);
            REG_WRAM_BANK: sel_wram = clamp_bank(32'(val[WRAM_BANK_W-1:0]), WRAM_BANKS);
            default: ;
        endcase
    endfunction

    // decode one access against the shadow stores and update them
    function automatic t_result map_access(logic wr, logic [ADDR_W-1:0] a,
                                           logic [DATA_W-1:0] d);
        t_result     r;
        t_area       area;
        int unsigned off;
        int unsigned key;
        bit          hole;
        r    = '0;
        hole = 1'b0;
        area = AREA_IE;
        off  = 0;
        if (a < ADDR_ROMX) begin
            area = AREA_ROM0;  off = 32'(a[13:0]);
        end else if (a < ADDR_VRAM) begin
            area = AREA_ROMX;  off = sel_rom * (1 << ROM_PAGE_W) + 32'(a[13:0]);
        end else if (a < ADDR_CRAM) begin
            area = AREA_VRAM;  off = sel_vram * (1 << VRAM_PAGE_W) + 32'(a[12:0]);
        end else if (a < ADDR_WRAM) begin
            area = AREA_CRAM;  off = sel_cram * (1 << CRAM_PAGE_W) + 32'(a[12:0]);
        end else if (a < ADDR_WRMX) begin
            area = AREA_WRAM0; off = 32'(a[11:0]);
        end else if (a < ADDR_ECHO) begin
            area = AREA_WRAMX; off = sel_wram * (1 << WRAM_PAGE_W) + 32'(a[11:0]);
        end else if (a < ADDR_ECHX) begin
            area = AREA_WRAM0; off = 32'(a[11:0]);
        end else if (a < ADDR_OAM) begin
            area = AREA_WRAMX; off = sel_wram * (1 << WRAM_PAGE_W) + 32'(a[11:0]);
        end else if (a < ADDR_HOLE) begin
            area = AREA_OAM;   off = 32'(a[7:0]);
        end else if (a < ADDR_IO) begin
            hole = 1'b1;
        end else if (a < ADDR_HRAM) begin
            area = AREA_IO;    off = 32'(a[6:0]);
        end else if (a < ADDR_IE) begin
            area = AREA_HRAM;  off = 32'(a[6:0]);
        end
        if (hole) begin
            r.bad = 1'b1;
        end else begin
            key = (int'(area) << 24) + off;
            if (wr == MODE_WRITE) begin
                shadow_mem[key] = d;
            end else if (shadow_mem.exists(key)) begin
                r.rd = shadow_mem[key];
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        case ($urandom_range(0, 12))
            0:  begin base = 16'h0000;  span = 16'h4000; end
            1:  begin base = ADDR_ROMX; span = 16'h4000; end
            2:  begin base = ADDR_VRAM; span = 16'h2000; end
            3:  begin base = ADDR_CRAM; span = 16'h2000; end
            4:  begin base = ADDR_WRAM; span = 16'h1000; end
            5:  begin base = ADDR_WRMX; span = 16'h1000; end
            6:  begin base = ADDR_ECHO; span = 16'h1000; end
            7:  begin base = ADDR_ECHX; span = 16'h0E00; end
            8:  begin base = ADDR_OAM;  span = 16'h00A0; end
            9:  begin base = ADDR_HOLE; span = 16'h0060; end
            10: begin base = ADDR_IO;   span = 16'h0080; end
            11: begin base = ADDR_HRAM; span = 16'h0080; end
            default: return 16'($urandom);
        endcase
        // region edges now and then
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? base : base + span - 16'd1;
        return base + 16'($urandom_range(0, 32'(span) - 32'd1));
    endfunction

    task automatic set_banks(input logic [CFG_W-1:0] rom, input logic [CFG_W-1:0] vram,
                             input logic [CFG_W-1:0] cram, input logic [CFG_W-1:0] wram);
        logic [CFG_W-1:0] vals [4];
        t_reg_idx         idx;
        vals = '{rom, vram, cram, wram};
        for (int k = 0; k < 4; k++) begin
            idx = t_reg_idx'(k);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            apply_bank(idx, vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_access(input logic wr, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d, input logic typed,
                               input t_result typed_res);
        t_result predicted;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {d, a};
        i_s_tuser  <= wr;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = map_access(wr, a, d);
        pending_results.push_back(typed ? typed_res : predicted);
        if (predicted.bad) n_hole++;
        if (wr == MODE_WRITE) n_writes++;
        else n_reads++;
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %0h bad_region %0b", o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.rd) begin
                    $error("read_data: expected %02h, got %02h", want.rd, o_m_tdata);
                    errors++;
                end
                if (o_m_tuser[0] !== want.bad) begin
                    $error("bad_region: expected %0b, got %0b", want.bad, o_m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic              wr;
        logic [ADDR_W-1:0] a;
        sel_rom  = 0;
        sel_vram = 0;
        sel_cram = 0;
        sel_wram = 0;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++)
            send_access(dir_rows[k].mode, dir_rows[k].addr, dir_rows[k].wdata,
                        dir_rows[k].typed, dir_rows[k].res);
        i_s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            idle_en = (p != PHASES - 1);
            case (p)
                0: set_banks(7'd127, 7'd1, 7'd3, 7'd6);
                1: set_banks(7'd127, 7'd1, 7'd3, 7'd7);
                2: set_banks(7'd0, 7'd0, 7'd0, 7'd0);
                3: set_banks(7'h7F, 7'h7E, 7'h7D, 7'h7F);
                default: set_banks(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                wr = 1'($urandom_range(0, 1));
                // reads mostly revisit recent writes, possibly under another bank
                if (wr == MODE_READ && written_addrs.size() != 0 && $urandom_range(0, 9) < 6)
                    a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                else
                    a = random_addr();
                if (wr == MODE_WRITE) begin
                    written_addrs.push_back(a);
                    if (written_addrs.size() > POOL_MAX) void'(written_addrs.pop_front());
                end
                send_access(wr, a, 8'($urandom), 1'b0, '0);
            end
            i_s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Covered %0d transactions (%0d reads, %0d writes, %0d in the unusable hole)",
                 n_reads + n_writes, n_reads, n_writes, n_hole);
        $display("across %0d bank settings including clamped and masked values.", PHASES + 1);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
